/* hw/rtl/lphash_pkg.sv */
`default_nettype none

package lphash_pkg;

    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

    // Remainder unit: radix-16 restoring steps over a 32-bit dividend.
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = 8;
    localparam int DIV_W          = DIV_RADIX_BITS * DIV_STEPS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ZERO    = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

endpackage

`default_nettype wire

/* hw/rtl/lphash_mod.sv */
`default_nettype none

// Key modulo table size, four quotient bits per cycle.
module lphash_mod #(
    parameter int MAX_SLOTS = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire [lphash_pkg::KEY_W-1:0]        i_key,
    input  wire [$clog2(MAX_SLOTS):0]          i_size,
    output logic                               o_done,
    output logic [$clog2(MAX_SLOTS)-1:0]       o_rem
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = IW + 1;

    logic [lphash_pkg::DIV_W-1:0]     r_dvd;
    logic [IW-1:0]                    r_rem;
    logic [IW-1:0]                    n_rem;
    logic [lphash_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                             r_busy;
    logic                             r_done;

    always_comb begin
        logic [IW-1:0] rem_t;
        logic [CW-1:0] trial;
        rem_t = r_rem;
        for (int i = 0; i < lphash_pkg::DIV_RADIX_BITS; i++) begin
            trial = {rem_t, r_dvd[lphash_pkg::DIV_W-1-i]};
            if (trial >= i_size) begin
                trial = trial - i_size;
            end
            rem_t = trial[IW-1:0];
        end
        n_rem = rem_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == lphash_pkg::DIV_CNT_W'(lphash_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {{(lphash_pkg::DIV_W - lphash_pkg::KEY_W){1'b0}}, i_key};
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << lphash_pkg::DIV_RADIX_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* hw/rtl/lphash_store.sv */
`default_nettype none

// Slot store: one write port, one read port with registered data.
module lphash_store #(
    parameter int DEPTH = 1024
) (
    input  wire                         i_clk,
    input  wire                         i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]     i_rd_addr,
    output lphash_pkg::t_slot           o_rd_data,
    input  wire                         i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  lphash_pkg::t_slot           i_wr_data
);

    lphash_pkg::t_slot r_mem [DEPTH];
    lphash_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/linear_probe_hash_table.sv */
`default_nettype none

// Open-addressing hash table with linear probing. Each request is an insert
// (op 0) or a lookup (op 1) of a 31-bit key; the home slot is key modulo the
// effective table size (table_size, with 0 read as 1 and values above
// MAX_SLOTS read as MAX_SLOTS), and probing walks forward one slot at a time
// with wrap-around until it meets the key, an empty slot (value zero) or has
// visited every slot in use. Keys and values sit together in one
// single-port-read, single-port-write memory of MAX_SLOTS entries. After
// reset a clearing pass writes every entry to empty, during which no request
// is accepted (table_size writes are taken at any time). After acceptance a
// request goes through the radix-16 remainder unit, a step that hands the
// home slot to the probe, the registered memory read of the home slot, the
// probe, which reads the slots in turn through the memory read port (1 to
// table size slots), and the load of the output register. The block returns
// to idle as that load happens. Requests are worked one at a time; the next
// request is accepted while a result still waits in the output register.
// Write table_size only while idle.
module linear_probe_hash_table #(
    parameter int MAX_SLOTS = 1024
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,

    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [lphash_pkg::CFG_W-1:0]       i_cfg_table_size,

    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_op,
    input  wire [lphash_pkg::KEY_W-1:0]       i_key,
    input  wire [lphash_pkg::VAL_W-1:0]       i_value,

    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [1:0]                        o_status,
    output logic                              o_found,
    output logic [lphash_pkg::VAL_W-1:0]      o_read_value
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = IW + 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration
    logic [lphash_pkg::CFG_W-1:0] r_table_size;
    logic [CW-1:0]                w_eff_size;

    // Request held during the probe
    lphash_pkg::t_op              r_op;
    logic [lphash_pkg::KEY_W-1:0] r_key;
    logic [lphash_pkg::VAL_W-1:0] r_val;
    logic [CW-1:0]                r_size;

    // Probe position and count of visited slots
    logic [IW-1:0]                r_idx;
    logic [CW-1:0]                r_cnt;
    logic [IW-1:0]                r_clr_addr;

    // Finished result waiting for the output register
    lphash_pkg::t_status          r_res_status;
    logic                         r_res_found;
    logic [lphash_pkg::VAL_W-1:0] r_res_value;

    // Output register
    logic                         r_out_valid;
    lphash_pkg::t_status          r_out_status;
    logic                         r_out_found;
    logic [lphash_pkg::VAL_W-1:0] r_out_value;

    // Remainder unit
    logic                         w_div_start;
    logic                         w_div_done;
    logic [IW-1:0]                w_div_rem;

    // Memory ports
    logic                         w_rd_en;
    logic [IW-1:0]                w_rd_addr;
    lphash_pkg::t_slot            w_rd_data;
    logic                         w_wr_en;
    logic [IW-1:0]                w_wr_addr;
    lphash_pkg::t_slot            w_wr_data;

    // Probe decisions
    logic                         w_in_accept;
    logic                         w_empty;
    logic                         w_hit;
    logic                         w_last;
    logic                         w_finish;
    logic                         w_insert_ok;
    logic [CW-1:0]                w_idx_inc;
    logic [IW-1:0]                w_next_idx;
    logic [CW-1:0]                w_cnt_inc;
    logic                         w_out_load;

    // Clamp the configured size to 1..MAX_SLOTS.
    always_comb begin
        if (r_table_size == '0) begin
            w_eff_size = CW'(1);
        end else if (32'(r_table_size) > 32'(MAX_SLOTS)) begin
            w_eff_size = CW'(MAX_SLOTS);
        end else begin
            w_eff_size = CW'(r_table_size);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= lphash_pkg::CFG_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_table_size;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_div_start = w_in_accept;

    lphash_mod #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_key   (i_key),
        .i_size  (w_eff_size),
        .o_done  (w_div_done),
        .o_rem   (w_div_rem)
    );

    // Slot check on the data just read at r_idx.
    assign w_empty     = (w_rd_data.value == '0);
    assign w_hit       = !w_empty && (w_rd_data.key == r_key);
    assign w_cnt_inc   = r_cnt + 1'b1;
    assign w_last      = (w_cnt_inc == r_size);
    assign w_finish    = w_empty || w_hit || w_last;
    assign w_idx_inc   = {1'b0, r_idx} + 1'b1;
    assign w_next_idx  = (w_idx_inc == r_size) ? '0 : w_idx_inc[IW-1:0];
    assign w_insert_ok = (r_op == lphash_pkg::OP_INSERT) && w_empty && (r_val != '0);

    // Issue the first read in S_READ; in S_CHECK read the next slot ahead so
    // that one slot is probed per cycle.
    assign w_rd_en   = (r_state == S_READ) || ((r_state == S_CHECK) && !w_finish);
    assign w_rd_addr = (r_state == S_READ) ? r_idx : w_next_idx;

    // Write during the clearing pass, or store the entry as the insert ends.
    // No read is issued in that cycle, so no read and write of one entry meet.
    assign w_wr_en   = (r_state == S_CLEAR) || ((r_state == S_CHECK) && w_insert_ok);
    assign w_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_idx;
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_wr_data = '0;
        end else begin
            w_wr_data.key   = r_key;
            w_wr_data.value = r_val;
        end
    end

    lphash_store #(
        .DEPTH (MAX_SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IW'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (w_div_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Latch the request; track the probe position.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op   <= lphash_pkg::t_op'(i_op);
            r_key  <= i_key;
            r_val  <= i_value;
            r_size <= w_eff_size;
        end
        if ((r_state == S_HASH) && w_div_done) begin
            r_idx <= w_div_rem;
            r_cnt <= '0;
        end else if ((r_state == S_CHECK) && !w_finish) begin
            r_idx <= w_next_idx;
            r_cnt <= w_cnt_inc;
        end
    end

    // Resolve the result as the probe ends.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_CHECK) && w_finish) begin
            r_res_found <= 1'b0;
            r_res_value <= '0;
            priority if (r_op == lphash_pkg::OP_LOOKUP) begin
                r_res_status <= lphash_pkg::ST_OK;
                r_res_found  <= w_hit;
                r_res_value  <= w_hit ? w_rd_data.value : '0;
            end else if (w_hit) begin
                r_res_status <= lphash_pkg::ST_PRESENT;
            end else if (r_val == '0) begin
                r_res_status <= lphash_pkg::ST_ZERO;
            end else if (!w_empty) begin
                r_res_status <= lphash_pkg::ST_FULL;
            end else begin
                r_res_status <= lphash_pkg::ST_OK;
            end
        end
    end

    // Output register: hold until taken, load when free or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_found      = r_out_found;
    assign o_read_value = r_out_value;

    // A request is worked alone: no second acceptance right after one.
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    // The probe never visits more slots than the table holds.
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_cnt < r_size))
        else $error("probe count ran past table size");

    // Memory writes come only from clearing or a successful insert.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> ((r_state == S_CLEAR) || (r_state == S_CHECK)))
        else $error("memory write outside clear or insert");

    // A found key is only reported with an ok status.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == lphash_pkg::ST_OK))
        else $error("found flag with non-ok status");

endmodule

`default_nettype wire
